[sv/ugds_pkg.sv]
// Shared types and constants of the undirected graph store with depth-first walk.
// Holds the payload structs, operation codes and the controller/datapath interface.
// No dependencies.
`default_nettype none

package ugds_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_WALK   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic       edge_found;
    logic [4:0] vertex_degree;
    logic [7:0] edge_total;
    logic [3:0] visit_vertex;
    logic       last;
  } out_item_t;

  // Commands from the controller; more than one group can be active at once.
  typedef struct packed {
    logic latch;
    logic clr;
    logic add_a;
    logic add_b;
    logic rm_init;
    logic rm_side;
    logic rm_rd;
    logic rm_ck;
    logic rm_fin;
    logic wk_init;
    logic wk_rd;
    logic wk_nb;
    logic wk_push;
    logic wk_pop;
    logic out_load;
    logic out_last;
    logic out_walk;
    logic out_pend;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_range;
    logic       a_ok;
    logic       found;
    logic       self_loop;
    logic       rm_end;
    logic       rm_side;
    logic       wk_has;
    logic       wk_new;
    logic       d_one;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/ugds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ugds_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/ugds_dpath.sv]
// Datapath of the graph store: neighbor RAM, list lengths, adjacency bits,
// walk stack, visited marks and the output register. Uses ugds_pkg and ugds_ram.
`default_nettype none

module ugds_dpath import ugds_pkg::*; #(
  parameter int VERTICES = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int ROWS   = (VERTICES < 16) ? VERTICES : 16;
  localparam int RW     = $clog2(ROWS);
  localparam int ADDR_W = RW + 4;

  logic [2:0]  op_q;
  logic [3:0]  a_q, b_q;
  logic        found_q;

  logic [4:0]  len_q [16];
  logic [15:0] loop_q;
  logic [15:0] adj_q [16];
  logic [7:0]  cnt_q;

  logic        side_q, hit_q;
  logic [4:0]  idx_q;

  logic [3:0]  stk_v_q [16];
  logic [4:0]  stk_p_q [16];
  logic [4:0]  dep_q;
  logic [15:0] vis_q;
  logic [3:0]  pend_q;

  logic        out_valid_q;
  out_item_t   out_q;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [3:0]        wdata, rdata;

  logic [3:0] rm_v, rm_u, tix, top_v, nb;
  logic [4:0] top_p, top_len, slot_w;
  logic       out_free;

  assign rm_v    = side_q ? b_q : a_q;
  assign rm_u    = side_q ? a_q : b_q;
  assign tix     = dep_q[3:0] - 4'd1;
  assign top_v   = stk_v_q[tix];
  assign top_p   = stk_p_q[tix];
  assign top_len = len_q[top_v];
  assign slot_w  = top_len - 5'd1 - top_p;
  assign nb      = rdata;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = {a_q[RW-1:0], len_q[a_q][3:0]};
    wdata = b_q;
    if (cmd_i.add_a) begin
      we = 1'b1;
    end else if (cmd_i.add_b) begin
      we    = 1'b1;
      waddr = {b_q[RW-1:0], len_q[b_q][3:0]};
      wdata = a_q;
    end else if (cmd_i.rm_ck && hit_q) begin
      // Entries behind the removed one move down by one slot.
      we    = 1'b1;
      waddr = {rm_v[RW-1:0], idx_q[3:0] - 4'd1};
      wdata = rdata;
    end
  end

  always_comb begin
    re    = cmd_i.rm_rd || cmd_i.wk_rd;
    raddr = cmd_i.rm_rd ? {rm_v[RW-1:0], idx_q[3:0]} : {top_v[RW-1:0], slot_w[3:0]};
  end

  ugds_ram #(.WIDTH(4), .DEPTH(ROWS * 16)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Item registers, the walk stack payload, the remove index and the output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= in_item_i.op;
      a_q     <= in_item_i.vertex_a;
      b_q     <= in_item_i.vertex_b;
      found_q <= adj_q[in_item_i.vertex_a][in_item_i.vertex_b];
    end
    if (cmd_i.wk_init) begin
      stk_v_q[0] <= a_q;
      stk_p_q[0] <= 5'd0;
      pend_q     <= a_q;
    end
    if (cmd_i.wk_nb) begin
      stk_p_q[tix] <= top_p + 5'd1;
    end
    if (cmd_i.wk_push) begin
      stk_v_q[dep_q[3:0]] <= nb;
      stk_p_q[dep_q[3:0]] <= 5'd0;
      pend_q              <= nb;
    end
    if (cmd_i.rm_init) begin
      idx_q <= 5'd0;
    end else if (cmd_i.rm_ck) begin
      idx_q <= idx_q + 5'd1;
    end
    if (cmd_i.out_load) begin
      out_q.edge_found    <= cmd_i.out_walk ? 1'b0 : found_q;
      out_q.vertex_degree <= len_q[a_q] + {4'd0, loop_q[a_q]};
      out_q.edge_total    <= cnt_q;
      out_q.visit_vertex  <= cmd_i.out_pend ? pend_q : 4'd0;
      out_q.last          <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        len_q[i] <= 5'd0;
        adj_q[i] <= 16'd0;
      end
      loop_q      <= 16'd0;
      cnt_q       <= 8'd0;
      side_q      <= 1'b0;
      hit_q       <= 1'b0;
      dep_q       <= 5'd0;
      vis_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        for (int i = 0; i < 16; i++) begin
          len_q[i] <= 5'd0;
          adj_q[i] <= 16'd0;
        end
        loop_q <= 16'd0;
        cnt_q  <= 8'd0;
      end
      if (cmd_i.add_a) begin
        len_q[a_q]      <= len_q[a_q] + 5'd1;
        adj_q[a_q][b_q] <= 1'b1;
        adj_q[b_q][a_q] <= 1'b1;
        cnt_q           <= cnt_q + 8'd1;
        if (a_q == b_q) begin
          loop_q[a_q] <= 1'b1;
        end
      end
      if (cmd_i.add_b) begin
        len_q[b_q] <= len_q[b_q] + 5'd1;
      end
      if (cmd_i.rm_init) begin
        side_q <= cmd_i.rm_side;
        hit_q  <= 1'b0;
      end
      if (cmd_i.rm_ck && !hit_q && rdata == rm_u) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.rm_fin) begin
        len_q[rm_v] <= len_q[rm_v] - 5'd1;
        if (!side_q) begin
          cnt_q           <= cnt_q - 8'd1;
          adj_q[a_q][b_q] <= 1'b0;
          adj_q[b_q][a_q] <= 1'b0;
          if (a_q == b_q) begin
            loop_q[a_q] <= 1'b0;
          end
        end
      end
      if (cmd_i.wk_init) begin
        vis_q <= 16'd1 << a_q;
        dep_q <= 5'd1;
      end
      if (cmd_i.wk_push) begin
        vis_q[nb] <= 1'b1;
        dep_q     <= dep_q + 5'd1;
      end
      if (cmd_i.wk_pop) begin
        dep_q <= dep_q - 5'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.a_ok      = ({3'b000, a_q} < 7'(VERTICES));
    sts_o.in_range  = ({3'b000, a_q} < 7'(VERTICES)) && ({3'b000, b_q} < 7'(VERTICES));
    sts_o.found     = found_q;
    sts_o.self_loop = (a_q == b_q);
    sts_o.rm_end    = (idx_q == len_q[rm_v]);
    sts_o.rm_side   = side_q;
    sts_o.wk_has    = (top_p < top_len);
    sts_o.wk_new    = !vis_q[nb];
    sts_o.d_one     = (dep_q == 5'd1);
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[sv/ugds_ctrl.sv]
// Controller state machine of the graph store; sequences the datapath
// through edits, list scans and the walk. Uses ugds_pkg.
`default_nettype none

module ugds_ctrl import ugds_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ADDA  = 4'd2;
  localparam logic [3:0] S_ADDB  = 4'd3;
  localparam logic [3:0] S_RMRD  = 4'd4;
  localparam logic [3:0] S_RMCK  = 4'd5;
  localparam logic [3:0] S_RMFIN = 4'd6;
  localparam logic [3:0] S_RES   = 4'd7;
  localparam logic [3:0] S_WINIT = 4'd8;
  localparam logic [3:0] S_WTOP  = 4'd9;
  localparam logic [3:0] S_WNB   = 4'd10;
  localparam logic [3:0] S_WEMIT = 4'd11;
  localparam logic [3:0] S_WFIN  = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        priority if (sts_i.op == OP_CLEAR) begin
          cmd_o.clr = 1'b1;
          state_d   = S_RES;
        end else if (sts_i.op == OP_ADD && sts_i.in_range && !sts_i.found) begin
          state_d = S_ADDA;
        end else if (sts_i.op == OP_REMOVE && sts_i.in_range && sts_i.found) begin
          cmd_o.rm_init = 1'b1;
          state_d       = S_RMRD;
        end else if (sts_i.op == OP_WALK && sts_i.a_ok) begin
          state_d = S_WINIT;
        end else begin
          state_d = S_RES;
        end
      end
      S_ADDA: begin
        cmd_o.add_a = 1'b1;
        state_d     = sts_i.self_loop ? S_RES : S_ADDB;
      end
      S_ADDB: begin
        cmd_o.add_b = 1'b1;
        state_d     = S_RES;
      end
      S_RMRD: begin
        if (sts_i.rm_end) begin
          state_d = S_RMFIN;
        end else begin
          cmd_o.rm_rd = 1'b1;
          state_d     = S_RMCK;
        end
      end
      S_RMCK: begin
        cmd_o.rm_ck = 1'b1;
        state_d     = S_RMRD;
      end
      S_RMFIN: begin
        cmd_o.rm_fin = 1'b1;
        if (!sts_i.rm_side && !sts_i.self_loop) begin
          // Second pass removes the mirror entry from vertex_b's list.
          cmd_o.rm_init = 1'b1;
          cmd_o.rm_side = 1'b1;
          state_d       = S_RMRD;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_walk = (sts_i.op == OP_WALK);
          state_d        = S_IDLE;
        end
      end
      S_WINIT: begin
        cmd_o.wk_init = 1'b1;
        state_d       = S_WTOP;
      end
      S_WTOP: begin
        if (sts_i.wk_has) begin
          cmd_o.wk_rd = 1'b1;
          state_d     = S_WNB;
        end else begin
          cmd_o.wk_pop = 1'b1;
          state_d      = sts_i.d_one ? S_WFIN : S_WTOP;
        end
      end
      S_WNB: begin
        cmd_o.wk_nb = 1'b1;
        state_d     = sts_i.wk_new ? S_WEMIT : S_WTOP;
      end
      S_WEMIT: begin
        // The previously found vertex goes out now that another one follows it.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_walk = 1'b1;
          cmd_o.out_pend = 1'b1;
          cmd_o.wk_push  = 1'b1;
          state_d        = S_WTOP;
        end
      end
      S_WFIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_walk = 1'b1;
          cmd_o.out_pend = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/undirected_graph_store_dfs_core.sv]
// Top level of the undirected graph store with depth-first walk.
// Instantiates ugds_ctrl and ugds_dpath; uses ugds_pkg.
//
// Usage: items enter on the in channel (in_valid_i/in_ready_o, in_item_i) and
// results leave on the out channel (out_valid_o/out_ready_i, out_item_o).
// One item is worked on at a time; in_ready_o is high only while idle.
// Clear, query and unmatched add/remove go from dispatch straight to the result.
// An add makes one RAM write per list. A remove scans each list with a read and
// a compare step. A walk reads each list entry it visits and checks its visited mark;
// each visited vertex gives one result, the final one has last set.
// Adds, removes and walks all share the single neighbor RAM port.
// Reset empties the graph at once (lengths, adjacency and self-loop bits, edge count); the
// neighbor RAM is not cleared. A stalled receiver holds the result in the
// output register and the block waits before loading the next one.
`default_nettype none

module undirected_graph_store_dfs_core import ugds_pkg::*; #(
  parameter int VERTICES = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  cmd_t cmd;
  sts_t sts;

  ugds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ugds_dpath #(.VERTICES(VERTICES)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[sv/ugds_checker.sv]
// Port-level checks of the graph store, bound to the top level.
// Uses ugds_pkg.
`default_nettype none

module ugds_checker import ugds_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_walk_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> !out_item_o.edge_found)
    else $error("walk result reports an edge");

  a_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.vertex_degree <= 5'd17)
    else $error("degree out of range");

endmodule

bind undirected_graph_store_dfs_core ugds_checker u_ugds_checker (.*);

`default_nettype wire
